@@ src/fpfa_pkg.sv @@
// Shared types, codes and defaults of the fixed-partition fit allocator.
`timescale 1ns / 1ps

package fpfa_pkg;

  // Default table geometry.
  localparam int SlotsDefault    = 16;
  localparam int SizeBitsDefault = 32;

  // Partition selection policy.
  typedef enum logic [1:0] {
    FitFirst = 2'd0,
    FitNext  = 2'd1,
    FitBest  = 2'd2,
    FitWorst = 2'd3
  } fit_mode_e;

  // Commands carried by an input beat.
  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdAlloc = 1'b1;

  // Result status codes.
  localparam logic [1:0] StatAllocated = 2'd0;
  localparam logic [1:0] StatNoFit     = 2'd1;
  localparam logic [1:0] StatLoaded    = 2'd2;
  localparam logic [1:0] StatInvalid   = 2'd3;

  // Register index, taken from paddr bit 2.
  localparam logic RegFitMode    = 1'b0;
  localparam logic RegSlotsInUse = 1'b1;

  localparam logic [4:0] SlotsInUseReset = 5'd16;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  slot_index;
    logic [31:0] size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  granted_slot;
    logic [31:0] remaining;
  } out_item_t;

endpackage

@@ src/fixed_partition_fit_allocator_unit.sv @@
// Top level of the fixed-partition fit allocator: table memory, scan sequencer, APB registers.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   fpfa_pkg::in_item_t  (cmd, slot_index, size)
// out       output     out_valid_o / out_ready_i fpfa_pkg::out_item_t (status, slot, remaining)
// config    input      APB psel/penable/pwrite   fit_mode at 0x0, slots_in_use at 0x4
//
// A load or a rejected request goes from acceptance through StFin to the result register.
// An allocation scans the n searched partitions through the one read port of the table
// memory, one entry per cycle, n being the saturated slot count
// (16 with all partitions searched).
// The block works on one beat at a time; the result register lets the next beat be
// accepted while the previous result still waits on out_ready_i.
// Reset is asynchronous and active low. It clears the per-entry valid bits, so every
// partition reads as zero until loaded; no clearing pass is needed.

module fixed_partition_fit_allocator_unit #(
  parameter int SLOTS     = fpfa_pkg::SlotsDefault,
  parameter int SIZE_BITS = fpfa_pkg::SizeBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fpfa_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fpfa_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IdxW = $clog2(SLOTS);
  localparam int CntW = $clog2(SLOTS + 1);
  // Bits of the input size that survive the reduction to SIZE_BITS.
  localparam int InW  = (SIZE_BITS < 32) ? SIZE_BITS : 32;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StUpd  = 4'b0100,
    StFin  = 4'b1000
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers. pready is tied high, so a write lands in the
  // access cycle.
  // ---------------------------------------------------------------------------
  fpfa_pkg::fit_mode_e fit_mode_q;
  logic [4:0]          slots_in_use_q;
  logic                cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q     <= fpfa_pkg::FitFirst;
      slots_in_use_q <= fpfa_pkg::SlotsInUseReset;
    end else if (cfg_we) begin
      if (paddr[2] == fpfa_pkg::RegFitMode) begin
        fit_mode_q <= fpfa_pkg::fit_mode_e'(pwdata[1:0]);
      end else begin
        slots_in_use_q <= pwdata[4:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == fpfa_pkg::RegSlotsInUse) begin
      prdata = {27'd0, slots_in_use_q};
    end else begin
      prdata = {30'd0, fit_mode_q};
    end
  end

  // Searched slot count, saturated into 1..SLOTS.
  logic [CntW-1:0] n_sat;
  always_comb begin
    if (slots_in_use_q == '0) begin
      n_sat = CntW'(1);
    end else if (int'(slots_in_use_q) > SLOTS) begin
      n_sat = CntW'(SLOTS);
    end else begin
      n_sat = CntW'(slots_in_use_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and working registers.
  // ---------------------------------------------------------------------------
  state_e              state_q;
  logic [IdxW-1:0]     next_start_q;
  logic [SLOTS-1:0]    entry_vld_q;
  logic                out_valid_q;
  fpfa_pkg::out_item_t out_data_q;
  fpfa_pkg::out_item_t res_q;

  logic [SIZE_BITS-1:0] req_q;
  logic [CntW-1:0]      n_q;
  logic [IdxW-1:0]      addr_q;      // next entry to read
  logic [CntW-1:0]      issued_q;    // reads issued so far
  logic                 rd_valid_q;  // read data below belongs to the scan
  logic                 rd_last_q;   // that data is the last searched entry
  logic [IdxW-1:0]      rd_idx_q;
  logic                 rd_vld_q;    // entry had been written since reset
  logic [SIZE_BITS-1:0] rd_data_q;
  logic                 found_q;
  logic [IdxW-1:0]      pick_q;
  logic [SIZE_BITS-1:0] best_q;

  logic                 in_fire;
  logic                 fin_fire;
  logic [SIZE_BITS-1:0] in_size;
  logic                 load_ok;
  logic [IdxW-1:0]      start_idx;
  logic                 rd_en;
  logic [CntW-1:0]      addr_inc;
  logic [SIZE_BITS-1:0] rd_value;
  logic                 fits;
  logic                 take;
  logic                 grant_ok;
  logic [SIZE_BITS-1:0] grant_rem;
  logic [CntW-1:0]      pick_inc;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  logic [SIZE_BITS-1:0] wr_data;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign fin_fire    = (state_q == StFin) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign in_size = SIZE_BITS'(in_data_i.size[InW-1:0]);
  assign load_ok = int'(in_data_i.slot_index) < SLOTS;

  // Next fit resumes at next_start unless the slot count is no longer above it.
  assign start_idx = ((fit_mode_q == fpfa_pkg::FitNext) && (CntW'(next_start_q) < n_sat))
                     ? next_start_q : '0;

  // One read per cycle until every searched entry has been issued, wrapping
  // the address at the end of the searched range.
  assign rd_en    = (state_q == StScan) && (issued_q != n_q);
  assign addr_inc = CntW'(addr_q) + CntW'(1);

  // An entry never loaded since reset holds zero.
  assign rd_value = rd_vld_q ? rd_data_q : '0;
  assign fits     = rd_value >= req_q;

  // Candidate update rule per policy. Strict compares keep the lowest slot
  // on ties, since entries of best and worst fit arrive in ascending order.
  always_comb begin
    case (fit_mode_q)
      fpfa_pkg::FitFirst: take = fits && !found_q;
      fpfa_pkg::FitNext:  take = fits && !found_q;
      fpfa_pkg::FitBest:  take = fits && (!found_q || (rd_value < best_q));
      fpfa_pkg::FitWorst: take = !found_q || (rd_value > best_q);
      default:            take = 1'b0;
    endcase
  end

  // Worst fit keeps the largest entry even when it is too small, so the
  // final fit check is done once for every policy.
  assign grant_ok  = found_q && (best_q >= req_q);
  assign grant_rem = best_q - req_q;
  assign pick_inc  = CntW'(pick_q) + CntW'(1);

  // Single write port: loads from the idle state, grants from the update state.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pick_q;
    wr_data = grant_rem;
    if (in_fire && (in_data_i.cmd == fpfa_pkg::CmdLoad) && load_ok) begin
      wr_en   = 1'b1;
      wr_addr = IdxW'(in_data_i.slot_index);
      wr_data = in_size;
    end else if ((state_q == StUpd) && grant_ok) begin
      wr_en = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Partition table: one write port, one read port with registered data.
  // Reads and writes never meet on one entry, since a scan only starts after
  // the previous beat's write-back.
  // ---------------------------------------------------------------------------
  logic [SIZE_BITS-1:0] table_mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= table_mem[addr_q];
    end
  end

  // ---------------------------------------------------------------------------
  // Control state.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      next_start_q <= '0;
      entry_vld_q  <= '0;
      out_valid_q  <= 1'b0;
      rd_valid_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_vld_q[wr_addr] <= 1'b1;
      end
      rd_valid_q <= rd_en;

      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (in_data_i.cmd == fpfa_pkg::CmdLoad) begin
              if (load_ok) begin
                next_start_q <= '0;
              end
              state_q <= StFin;
            end else if (in_size == '0) begin
              state_q <= StFin;
            end else begin
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          if (rd_valid_q && rd_last_q) begin
            state_q <= StUpd;
          end
        end
        StUpd: begin
          if (grant_ok) begin
            next_start_q <= (pick_inc >= n_q) ? '0 : IdxW'(pick_inc);
          end
          state_q <= StFin;
        end
        StFin: begin
          if (fin_fire) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      out_data_q <= res_q;
    end

    if (rd_en) begin
      rd_idx_q  <= addr_q;
      rd_vld_q  <= entry_vld_q[addr_q];
      rd_last_q <= (issued_q + CntW'(1)) == n_q;
      addr_q    <= (addr_inc >= n_q) ? '0 : IdxW'(addr_inc);
      issued_q  <= issued_q + CntW'(1);
    end

    if (rd_valid_q && take) begin
      found_q <= 1'b1;
      pick_q  <= rd_idx_q;
      best_q  <= rd_value;
    end

    if (in_fire) begin
      req_q    <= in_size;
      n_q      <= n_sat;
      addr_q   <= start_idx;
      issued_q <= '0;
      found_q  <= 1'b0;
      if ((in_data_i.cmd == fpfa_pkg::CmdLoad) && load_ok) begin
        res_q <= '{status:       fpfa_pkg::StatLoaded,
                   granted_slot: in_data_i.slot_index,
                   remaining:    32'(in_size)};
      end else begin
        res_q <= '{status: fpfa_pkg::StatInvalid, granted_slot: 4'd0, remaining: 32'd0};
      end
    end

    if (state_q == StUpd) begin
      if (grant_ok) begin
        res_q <= '{status:       fpfa_pkg::StatAllocated,
                   granted_slot: 4'(pick_q),
                   remaining:    32'(grant_rem)};
      end else begin
        res_q <= '{status: fpfa_pkg::StatNoFit, granted_slot: 4'd0, remaining: 32'd0};
      end
    end
  end

endmodule

@@ src/fpfa_checker.sv @@
// Port-level assertions for the fixed-partition fit allocator, bound to its top level.
`timescale 1ns / 1ps

module fpfa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input fpfa_pkg::out_item_t out_data_o
);

  // A result beat that is not taken stays, with its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // One beat is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again while a beat is in work");

  // A refused request reports no slot and no size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.status == fpfa_pkg::StatNoFit) ||
                    (out_data_o.status == fpfa_pkg::StatInvalid))
    |-> (out_data_o.granted_slot == 4'd0) && (out_data_o.remaining == 32'd0))
    else $error("refused request carries slot or size");

  // A beat accepted while the output is free is still in work or has raised its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> ##1 out_valid_o || !in_ready_o)
    else $error("sequencer returned to idle without a result");

endmodule

bind fixed_partition_fit_allocator_unit fpfa_checker u_fpfa_checker (.*);
